// File: design/thread_base_context_table_core_macros.svh
// Assertion macros shared by the thread context table RTL.
`ifndef THREAD_BASE_CONTEXT_TABLE_CORE_MACROS_SVH
`define THREAD_BASE_CONTEXT_TABLE_CORE_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define TBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbc: same-cycle check failed");

// Next-cycle implication, gated off during reset.
`define TBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbc: next-cycle check failed");

`endif

// File: design/tbc_pkg.sv
// Types and constants shared by the thread context table modules.
package tbc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int OP_W        = 3;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 64;
    localparam int IN_TDATA_W  = KEY_W + DATA_W + DATA_W;
    localparam int OUT_TDATA_W = DATA_W;

    typedef enum logic [OP_W-1:0] {
        OP_SET_FS     = 3'd0,
        OP_GET_FS     = 3'd1,
        OP_SET_GS     = 3'd2,
        OP_GET_GS     = 3'd3,
        OP_SET_TID    = 3'd4,
        OP_SET_ROBUST = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PICK,
        ST_ACCESS,
        ST_REPLY
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic ready;
        logic compare;
        logic pick;
        logic access;
        logic load;
    } ctl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;
    } ctl_sts_t;

endpackage

// File: design/tbc_ctrl.sv
// Sequencer for one request: capture, compare, select, access, reply.
module tbc_ctrl
    import tbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:  state_next = ST_PICK;
            ST_PICK:   state_next = ST_ACCESS;
            ST_ACCESS: state_next = ST_REPLY;
            ST_REPLY:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.ready   = 1'b1;
            ST_MATCH:  cmd.compare = 1'b1;
            ST_PICK:   cmd.pick    = 1'b1;
            ST_ACCESS: cmd.access  = 1'b1;
            ST_REPLY:  cmd.load    = sts.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

// File: design/tbc_datapath.sv
// Key table, match and allocate logic, context stores and output register.
module tbc_datapath
    import tbc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctl_cmd_t               cmd,
    output ctl_sts_t               sts,
    input  logic                   in_valid,
    input  logic [OP_W-1:0]        in_op,
    input  logic [IN_TDATA_W-1:0]  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_ok,
    output logic [OUT_TDATA_W-1:0] out_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // captured request
    opcode_t             op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [DATA_W-1:0]   len_reg;

    // key table, in flops with per-entry valid and field-written bits
    logic [ENTRIES-1:0]  valid_reg;
    logic [KEY_W-1:0]    key_arr_reg [ENTRIES];
    logic [ENTRIES-1:0]  fs_set_reg;
    logic [ENTRIES-1:0]  gs_set_reg;

    // context stores
    logic [DATA_W-1:0]   fs_mem    [ENTRIES];
    logic [DATA_W-1:0]   gs_mem    [ENTRIES];
    logic [DATA_W-1:0]   tid_mem   [ENTRIES];
    logic [DATA_W-1:0]   rhead_mem [ENTRIES];
    logic [DATA_W-1:0]   rlen_mem  [ENTRIES];

    logic [ENTRIES-1:0]  match_reg;
    logic [ENTRIES-1:0]  match_next;
    logic [ENTRIES-1:0]  free_reg;
    logic [ENTRIES-1:0]  free_next;
    logic                hit_reg;
    logic                room_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    slot_next;
    logic [IDX_W-1:0]    match_idx;
    logic [IDX_W-1:0]    free_idx;

    logic                ok_reg;
    logic                known_reg;
    logic [DATA_W-1:0]   fs_rd_reg;
    logic [DATA_W-1:0]   gs_rd_reg;

    logic                out_valid_reg;
    logic                out_ok_reg;
    logic [DATA_W-1:0]   out_data_reg;

    logic                is_read;
    logic                is_write;
    logic                do_write;
    logic [DATA_W-1:0]   reply_data;

    always_comb
    begin
        is_read  = (op_reg == OP_GET_FS) || (op_reg == OP_GET_GS);
        is_write = (op_reg == OP_SET_FS) || (op_reg == OP_SET_GS) ||
                   (op_reg == OP_SET_TID) || (op_reg == OP_SET_ROBUST);
        do_write = is_write && (hit_reg || room_reg);
    end

    // compare every entry against the captured key
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_next[i] = valid_reg[i] && (key_arr_reg[i] == key_reg);
            free_next[i]  = !valid_reg[i];
        end
    end

    // lowest set index wins
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                match_idx = IDX_W'(i);
            end
            if (free_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        slot_next = (|match_reg) ? match_idx : free_idx;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && in_valid)
        begin
            op_reg  <= opcode_t'(in_op);
            key_reg <= in_data[KEY_W-1:0];
            val_reg <= in_data[KEY_W+DATA_W-1:KEY_W];
            len_reg <= in_data[IN_TDATA_W-1:KEY_W+DATA_W];
        end
        if (cmd.compare)
        begin
            match_reg <= match_next;
            free_reg  <= free_next;
        end
        if (cmd.pick)
        begin
            hit_reg  <= |match_reg;
            room_reg <= |free_reg;
            slot_reg <= slot_next;
        end
        if (cmd.access)
        begin
            fs_rd_reg <= fs_mem[slot_reg];
            gs_rd_reg <= gs_mem[slot_reg];
            ok_reg    <= is_read ? hit_reg : do_write;
            known_reg <= is_read && hit_reg &&
                         ((op_reg == OP_GET_FS) ? fs_set_reg[slot_reg] : gs_set_reg[slot_reg]);
        end
    end

    // store writes
    always_ff @(posedge clk)
    begin
        if (cmd.access && do_write)
        begin
            key_arr_reg[slot_reg] <= key_reg;
            case (op_reg)
                OP_SET_FS:     fs_mem[slot_reg]  <= val_reg;
                OP_SET_GS:     gs_mem[slot_reg]  <= val_reg;
                OP_SET_TID:    tid_mem[slot_reg] <= val_reg;
                OP_SET_ROBUST:
                begin
                    rhead_mem[slot_reg] <= val_reg;
                    rlen_mem[slot_reg]  <= len_reg;
                end
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fs_set_reg <= '0;
            gs_set_reg <= '0;
        end
        else if (cmd.access && do_write)
        begin
            valid_reg[slot_reg] <= 1'b1;
            if (op_reg == OP_SET_FS)
            begin
                fs_set_reg[slot_reg] <= 1'b1;
            end
            if (op_reg == OP_SET_GS)
            begin
                gs_set_reg[slot_reg] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        reply_data = '0;
        if (known_reg)
        begin
            reply_data = (op_reg == OP_GET_FS) ? fs_rd_reg : gs_rd_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_ok_reg   <= ok_reg;
            out_data_reg <= reply_data;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_ok       = out_ok_reg;
    assign out_data     = out_data_reg;

endmodule

// File: design/thread_base_context_table_core.sv
// Top level of the per-thread context table: stream ports, sequencer and datapath.
//
// Per-thread context table. Each input beat is one request (opcode on s_tuser,
// thread id, value and length on s_tdata) and yields exactly one output beat
// (ok on m_tuser, read data on m_tdata). Set opcodes find the thread's entry or
// claim the lowest free one; get opcodes only look up and return zero for an
// unknown thread. One request is taken at a time: the sequencer captures it,
// then compares all keys, selects the entry, accesses the context stores and
// loads the output register, one step per cycle under a single sequencer,
// before it accepts the next request. The output register
// holds a finished result while the next request is taken; a stalled output
// holds the sequencer in its reply step. Reset empties the table at once
// through per-entry valid bits, so there is no clearing pass.

`include "thread_base_context_table_core_macros.svh"

module thread_base_context_table_core
    import tbc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // thread_id[31:0], value[95:32], length[159:96]
    input  logic [OP_W-1:0]        s_tuser,   // opcode[2:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // read_data[63:0]
    output logic                   m_tuser    // ok[0]
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // sequence one request at a time
    tbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table, stores and output register
    tbc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ok    (m_tuser),
        .out_data  (m_tdata)
    );

    assign s_tready = cmd.ready;

    // an accepted beat starts the key compare on the next cycle
    `TBC_ASSERT_NEXT(a_accept_compare, clk, rst_n, s_tvalid && s_tready, cmd.compare && !s_tready)
    // the sequencer issues at most one step per cycle
    `TBC_ASSERT_NOW(a_one_step, clk, rst_n, 1'b1,
                    $onehot0({cmd.ready, cmd.compare, cmd.pick, cmd.access, cmd.load}))
    // a loaded result shows up on the output side
    `TBC_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.load, m_tvalid)
    // never overwrite a result that is still waiting
    `TBC_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.load, !m_tvalid || m_tready)

endmodule

// File: tb/sv/thread_base_context_table_checker.sv
// Scoreboard for the thread context table: predicts each result beat and compares it.
module thread_base_context_table_checker
    import tbc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // thread_id[31:0], value[95:32], length[159:96]
    input  logic [OP_W-1:0]        s_tuser,   // opcode[2:0]
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // read_data[63:0]
    input  logic                   m_tuser,   // ok[0]
    output int                     mismatches,
    output int                     pending,
    output int                     checked,
    output int                     read_hits,
    output int                     full_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] data;
    } ctx_reply_t;

    ctx_reply_t        reply_q [$];

    // Shadow copy of the context table.
    logic              ctx_valid [ENTRIES_DEF];
    logic [KEY_W-1:0]  ctx_key   [ENTRIES_DEF];
    logic [DATA_W-1:0] ctx_fs    [ENTRIES_DEF];
    logic [DATA_W-1:0] ctx_gs    [ENTRIES_DEF];
    logic [DATA_W-1:0] ctx_tid   [ENTRIES_DEF];
    logic [DATA_W-1:0] ctx_rhead [ENTRIES_DEF];
    logic [DATA_W-1:0] ctx_rlen  [ENTRIES_DEF];

    function automatic int find_slot(logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES_DEF; i++)
        begin
            if (ctx_valid[i] && ctx_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Lowest matching entry, else lowest free entry (claimed), else -1.
    function automatic int claim_slot(logic [KEY_W-1:0] key);
        int slot;
        slot = find_slot(key);
        if (slot >= 0)
            return slot;
        for (int i = 0; i < ENTRIES_DEF; i++)
        begin
            if (!ctx_valid[i])
            begin
                ctx_valid[i] = 1'b1;
                ctx_key[i]   = key;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic ctx_reply_t serve_request(logic [OP_W-1:0]   op,
                                                 logic [KEY_W-1:0]  key,
                                                 logic [DATA_W-1:0] val,
                                                 logic [DATA_W-1:0] len);
        ctx_reply_t reply;
        int         slot;
        reply = '0;
        case (op)
            OP_GET_FS, OP_GET_GS:
            begin
                slot = find_slot(key);
                if (slot >= 0)
                begin
                    reply.ok   = 1'b1;
                    reply.data = (op == OP_GET_FS) ? ctx_fs[slot] : ctx_gs[slot];
                end
            end
            OP_SET_FS, OP_SET_GS, OP_SET_TID, OP_SET_ROBUST:
            begin
                slot = claim_slot(key);
                if (slot >= 0)
                begin
                    reply.ok = 1'b1;
                    case (op)
                        OP_SET_FS:  ctx_fs[slot]  = val;
                        OP_SET_GS:  ctx_gs[slot]  = val;
                        OP_SET_TID: ctx_tid[slot] = val;
                        default:
                        begin
                            ctx_rhead[slot] = val;
                            ctx_rlen[slot]  = len;
                        end
                    endcase
                end
            end
            default: ;  // spare opcodes leave the table alone
        endcase
        return reply;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (mismatches < MAX_PRINTS)
            $display("%0t checker: %s, expected %h got %h", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ctx_reply_t want;
        ctx_reply_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES_DEF; i++)
            begin
                ctx_valid[i] = 1'b0;
                ctx_key[i]   = '0;
                ctx_fs[i]    = '0;
                ctx_gs[i]    = '0;
                ctx_tid[i]   = '0;
                ctx_rhead[i] = '0;
                ctx_rlen[i]  = '0;
            end
            reply_q.delete();
            mismatches   = 0;
            pending      = 0;
            checked      = 0;
            read_hits    = 0;
            full_rejects = 0;
        end
        else
        begin
            // Check the result beat first: it can never belong to a request taken this edge.
            if (m_tvalid && m_tready)
            begin
                if (reply_q.size() == 0)
                    report_mismatch("result beat with no request outstanding", '0, m_tdata);
                else
                begin
                    want = reply_q.pop_front();
                    checked++;
                    if (m_tuser !== want.ok)
                        report_mismatch("ok flag", DATA_W'(want.ok), DATA_W'(m_tuser));
                    if (m_tdata !== want.data)
                        report_mismatch("read_data", want.data, m_tdata);
                end
            end
            if (s_tvalid && s_tready)
            begin
                got = serve_request(s_tuser, s_tdata[KEY_W-1:0],
                                    s_tdata[KEY_W+DATA_W-1:KEY_W],
                                    s_tdata[IN_TDATA_W-1:KEY_W+DATA_W]);
                if ((s_tuser == OP_GET_FS || s_tuser == OP_GET_GS) && got.ok)
                    read_hits++;
                if ((s_tuser == OP_SET_FS || s_tuser == OP_SET_GS || s_tuser == OP_SET_TID
                     || s_tuser == OP_SET_ROBUST) && !got.ok)
                    full_rejects++;
                reply_q.push_back(got);
            end
            pending = reply_q.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the thread context table: clock, reset, stimulus and verdict.
module tb_top
    import tbc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes the block leaves unused; they still return one result beat.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS  = 925;
    localparam int PRESSURE_ITEMS = 60;
    localparam int STEADY_ITEMS  = 150;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 20;
    localparam int IDLE_LIMIT    = 2000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // thread_id[31:0], value[95:32], length[159:96]
    logic [OP_W-1:0]        s_tuser;   // opcode[2:0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // read_data[63:0]
    logic                   m_tuser;   // ok[0]

    int mismatches;
    int pending;
    int checked;
    int read_hits;
    int full_rejects;

    int sent;
    // Phase controls shared by the sender and the receiver.
    logic hold_req;       // receiver: hold off for HOLD_CYCLES
    logic sender_steady;  // sender: no gaps
    logic link_steady;    // both sides: no gaps, no stalls

    logic [KEY_W-1:0] known_ids [$];

    thread_base_context_table_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    thread_base_context_table_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked),
        .read_hits    (read_hits),
        .full_rejects (full_rejects)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // 64-bit word that lands on the extremes now and then.
    function automatic logic [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Offer one request beat, hold it until taken, then maybe idle.
    // Called at a falling edge; returns at a falling edge.
    task automatic send_request(logic [OP_W-1:0]   op,
                                logic [KEY_W-1:0]  key,
                                logic [DATA_W-1:0] val,
                                logic [DATA_W-1:0] len);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {len, val, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
        gap = (sender_steady || link_steady) ? 0 : pick_gap();
        if (gap > 0)
        begin
            // Drop valid and scribble on the bus while idle.
            s_tvalid <= 1'b0;
            s_tuser  <= OP_W'($urandom);
            s_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom};
            repeat (gap) @(negedge clk);
        end
    endtask

    // Random request: mostly ids already in the table, some near misses, some fresh.
    task automatic send_random_request();
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        int               r;
        r = $urandom_range(0, 99);
        if (r < 18)
            op = OP_GET_FS;
        else if (r < 36)
            op = OP_GET_GS;
        else if (r < 52)
            op = OP_SET_FS;
        else if (r < 66)
            op = OP_SET_GS;
        else if (r < 78)
            op = OP_SET_TID;
        else if (r < 94)
            op = OP_SET_ROBUST;
        else if (r < 97)
            op = OP_SPARE_A;
        else
            op = OP_SPARE_B;
        r = $urandom_range(0, 99);
        key = known_ids[$urandom_range(0, known_ids.size() - 1)];
        if (r >= 85)
            key = $urandom;
        else if (r >= 75)
            key = key ^ (32'h1 << $urandom_range(0, KEY_W - 1));
        send_request(op, key, pick_word(), pick_word());
    endtask

    task automatic wait_all_results();
        while (pending != 0)
            @(negedge clk);
    endtask

    // Receiver: random stalls, a long hold-off on request, none in steady phases.
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (link_steady)
                m_tready <= 1'b1;
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                stall = pick_gap();
                m_tready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("tb_top: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        hold_req      = 1'b0;
        sender_steady = 1'b0;
        link_steady   = 1'b0;
        sent          = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reads on an empty table, field extremes, spare opcodes.
        send_request(OP_GET_FS, 32'h0, '1, '1);
        send_request(OP_SET_FS, 32'h0, '1, '0);
        known_ids.push_back(32'h0);
        send_request(OP_GET_FS, 32'h0, '0, '0);
        send_request(OP_SET_GS, '1, 64'h8000_0000_0000_0001, '1);
        known_ids.push_back('1);
        send_request(OP_GET_GS, '1, '0, '0);
        // Claimed entry whose fs base was never written reads back zero.
        send_request(OP_GET_FS, '1, '0, '0);
        send_request(OP_SET_TID, 32'h0, 64'hA5A5_A5A5_A5A5_A5A5, '0);
        send_request(OP_SET_ROBUST, 32'h0, '1, '1);
        send_request(OP_SET_ROBUST, 32'h5A5A_5A5A, '0, 64'h5555_5555_5555_5555);
        known_ids.push_back(32'h5A5A_5A5A);
        send_request(OP_SPARE_A, 32'h0, '1, '1);
        send_request(OP_SPARE_B, '1, '1, '1);
        // Fill the remaining entries with walking-one ids.
        for (int k = 0; known_ids.size() < ENTRIES_DEF; k++)
        begin
            send_request(OP_SET_GS, 32'h1 << k, {$urandom, $urandom}, '0);
            known_ids.push_back(32'h1 << k);
        end
        // Full table: a new id is refused and stays unknown.
        send_request(OP_SET_TID, 32'h1234_5678, '1, '0);
        send_request(OP_GET_GS, 32'h1234_5678, '0, '0);

        // Pause the sender until the table has answered everything.
        s_tvalid <= 1'b0;
        wait_all_results();
        @(negedge clk);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 350)
            begin
                // Hold off the receiver while the sender streams back to back.
                hold_req      = 1'b1;
                sender_steady = 1'b1;
            end
            if (i == 350 + PRESSURE_ITEMS)
            begin
                sender_steady = 1'b0;
                s_tvalid <= 1'b0;
                wait_all_results();
                @(negedge clk);
            end
            if (i == 500)
                link_steady = 1'b1;
            if (i == 500 + STEADY_ITEMS)
                link_steady = 1'b0;
            send_random_request();
        end

        s_tvalid <= 1'b0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("tb_top: %0d requests sent, %0d results checked, %0d mismatches",
                 sent, checked, mismatches);
        $display("tb_top: %0d read hits, %0d writes refused on a full table",
                 read_hits, full_rejects);
        if (mismatches == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
